/* hdl/htlp_pkg.sv */
package htlp_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam int LOAD_LIMIT = 80;
  localparam int PERCENT = 100;

  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_PUT = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_UPD = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef logic [1:0] status_t;

endpackage

/* hdl/htlp_ram.sv */
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hash_table_linear_probe_unit.sv */
// channel | handshake           | fields                     | dir
// in      | in_valid/in_ready   | mode key key_len value_in  | in
// out     | out_valid/out_ready | status value_out load_high | out
// Item: an accept step, then the key hashed one byte a cycle (prime multiply as
// shift and add), the hash reduced modulo TABLE_SLOTS in 16-bit chunks, then a
// RAM read and a compare per probed slot over up to TABLE_SLOTS slots, a write-back
// when a PUT or DEL writes a slot, and a result step; MODE_RSVD goes straight to result.
// After reset a clearing pass over all TABLE_SLOTS entries wipes the slot RAM;
// in_ready stays low meanwhile. One transaction in flight; out stall holds the result.
module hash_table_linear_probe_unit #(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [3:0]  key_len,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic        load_high
);

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int EW = 1 + 4 + 64 + VW;
  localparam int LOAD_LIMIT_C = htlp_pkg::LOAD_LIMIT;
  localparam int LOAD_THR = (LOAD_LIMIT_C + 1) * TABLE_SLOTS;
  // floor(2^32 / slots): quotient estimate is at most one short
  localparam logic [63:0] RECIP64 = 64'h0000_0001_0000_0000 / 64'(TABLE_SLOTS);
  localparam logic [31:0] RECIP = RECIP64[31:0];
  localparam logic [16:0] NSL = 17'(TABLE_SLOTS);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_WB = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_MOD = 3'd6;

  logic [2:0] state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] occupancy;
  logic [1:0] op;
  logic [63:0] k;
  logic [3:0] len;
  logic [VW-1:0] val;
  logic [63:0] h;
  logic [3:0] bidx;
  logic [AW-1:0] slot;
  logic rd_pend;
  logic [EW-1:0] wr_data;
  logic we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  htlp_pkg::status_t st;
  logic [31:0] found;
  logic [1:0] mph;
  logic [1:0] mchunk;
  logic [15:0] rem;
  logic [31:0] mx;
  logic [63:0] mprod;
  logic [32:0] mqn;

  logic [3:0] len_sat;
  logic [63:0] kmask;
  logic [63:0] hx;
  logic [63:0] hmul;
  logic r_valid;
  logic [3:0] r_len;
  logic [63:0] r_key;
  logic [VW-1:0] r_val;
  logic match;
  logic [31:0] mod_x;
  logic [63:0] mod_prod;
  logic [48:0] mod_qn;
  logic [32:0] mod_diff;
  logic [32:0] mod_rem;

  always_comb begin
    len_sat = (key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len;
    kmask = (len_sat >= 4'd8) ? '1 : ((64'd1 << {len_sat[2:0], 3'b000}) - 64'd1);
    hx = h ^ {56'd0, k[{bidx[2:0], 3'b000} +: 8]};
    // prime is 2^40 + 0x1b3
    hmul = (hx << 40) + (hx * 64'h1b3);
    {r_valid, r_len, r_key, r_val} = rdata;
    match = r_valid && r_len == len && r_key == k;
    // modulo by 16-bit chunks, top first: remainder kept below the slot count
    mod_x = {rem, h[63:48]};
    mod_prod = {32'd0, mod_x} * {32'd0, RECIP};
    mod_qn = {17'd0, mprod[63:32]} * {32'd0, NSL};
    mod_diff = {1'b0, mx} - mqn;
    mod_rem = (mod_diff >= {16'd0, NSL}) ? (mod_diff - {16'd0, NSL}) : mod_diff;
  end

  assign raddr = slot;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status = st;
  assign value_out = found;
  assign load_high = (32'(occupancy) * 32'(htlp_pkg::PERCENT)) >= 32'(LOAD_THR);

  htlp_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_data),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      occupancy <= '0;
      waddr <= '0;
      wr_data <= '0;
      we <= 1'b0;
    end else begin
      we <= (state == S_CLR) || (state == S_WB);
      case (state)
        S_CLR: begin
          waddr <= cnt[AW-1:0];
          wr_data <= '0;
          if (cnt == CW'(TABLE_SLOTS - 1)) state <= S_IDLE;
          cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= mode;
            len <= len_sat;
            k <= key & kmask;
            val <= value_in[VW-1:0];
            h <= htlp_pkg::FNV_BASIS;
            bidx <= '0;
            found <= '0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (bidx == len) begin
            cnt <= '0;
            rd_pend <= 1'b0;
            rem <= '0;
            mph <= '0;
            mchunk <= '0;
            if (op == htlp_pkg::MODE_PUT) st <= htlp_pkg::ST_FULL;
            else st <= htlp_pkg::ST_MISS;
            if (op == htlp_pkg::MODE_RSVD) state <= S_OUT;
            else state <= S_MOD;
          end else begin
            h <= hmul;
            bidx <= bidx + 1'b1;
          end
        end
        S_MOD: begin
          if (mph == 2'd0) begin
            mx <= mod_x;
            mprod <= mod_prod;
            mph <= 2'd1;
          end else if (mph == 2'd1) begin
            mqn <= mod_qn[32:0];
            mph <= 2'd2;
          end else begin
            rem <= mod_rem[15:0];
            h <= {h[47:0], 16'd0};
            mph <= 2'd0;
            mchunk <= mchunk + 1'b1;
            if (mchunk == 2'd3) begin
              slot <= mod_rem[AW-1:0];
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          // one read in flight: rd_pend marks that rdata is for slot
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (op == htlp_pkg::MODE_PUT && !r_valid) begin
              st <= htlp_pkg::ST_OK;
              wr_data <= {1'b1, len, k, val};
              occupancy <= occupancy + 1'b1;
              state <= S_WB;
            end else if (match) begin
              st <= (op == htlp_pkg::MODE_PUT) ? htlp_pkg::ST_UPD : htlp_pkg::ST_OK;
              if (op == htlp_pkg::MODE_GET) begin
                found <= 32'(r_val);
                state <= S_OUT;
              end else begin
                wr_data <= (op == htlp_pkg::MODE_PUT) ? {1'b1, len, k, val}
                                                       : {1'b0, len, k, val};
                if (op == htlp_pkg::MODE_DEL && occupancy != '0)
                  occupancy <= occupancy - 1'b1;
                state <= S_WB;
              end
            end else if (cnt == CW'(TABLE_SLOTS - 1)) begin
              state <= S_OUT;
            end else begin
              cnt <= cnt + 1'b1;
              slot <= (slot == AW'(TABLE_SLOTS - 1)) ? '0 : slot + 1'b1;
            end
          end
        end
        S_WB: begin
          waddr <= slot;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_CLR;
      endcase
    end
  end

endmodule

/* hdl/htlp_checker.sv */
module htlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] value_out
);

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted twice");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out))
    else $error("result dropped");
  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != htlp_pkg::ST_OK |-> value_out == 32'd0)
    else $error("value on non-hit");

endmodule

bind hash_table_linear_probe_unit htlp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .value_out(value_out)
);
